// ----- hdl/sci_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_pkg
// Shared types, constants and helper functions for the slave clock impulse
// driver.
// ----------------------------------------------------------------------------
package sci_pkg;

  localparam int TIME_W                = 10;
  localparam int MINUTES_PER_CYCLE_DEF = 12 * 60;
  localparam int WAIT_BITS_DEF         = 16;
  localparam int CFG_DATA_W            = 16;
  localparam int CFG_INDEX_W           = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PULSE_SELECT    = 2'd0,
    REG_CATCH_UP_GAP    = 2'd1,
    REG_RELEASE_RECHECK = 2'd2,
    REG_REARM_POLL      = 2'd3
  } cfg_reg_t;

  localparam logic [4:0]  PULSE_SELECT_RST    = 5'd0;
  localparam logic [15:0] CATCH_UP_GAP_RST    = 16'd500;
  localparam logic [15:0] RELEASE_RECHECK_RST = 16'd10;
  localparam logic [7:0]  REARM_POLL_RST      = 8'd5;

  // Coil drive levels: bit 0 is bridge half A, bit 1 is bridge half B.
  localparam logic [1:0] COIL_NONE = 2'b00;
  localparam logic [1:0] COIL_A    = 2'b01;
  localparam logic [1:0] COIL_B    = 2'b10;

  typedef struct packed {
    logic [4:0]  pulse_select;
    logic [15:0] catch_up_gap;
    logic [15:0] release_recheck;
    logic [7:0]  rearm_poll;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] true_time;
  } minute_evt_t;

  function automatic logic [TIME_W-1:0] next_minute(input logic [TIME_W-1:0] t,
                                                    input logic [TIME_W-1:0] limit);
    logic [TIME_W:0] n;
    n = {1'b0, t} + {{TIME_W{1'b0}}, 1'b1};
    return (n >= {1'b0, limit}) ? '0 : n[TIME_W-1:0];
  endfunction

  // Impulse length in milliseconds for each select code.
  function automatic logic [9:0] pulse_ms(input logic [4:0] sel);
    logic [9:0] ms;
    case (sel)
      5'd0:  ms = 10'd130;
      5'd1:  ms = 10'd140;
      5'd2:  ms = 10'd150;
      5'd3:  ms = 10'd160;
      5'd4:  ms = 10'd170;
      5'd5:  ms = 10'd180;
      5'd6:  ms = 10'd190;
      5'd7:  ms = 10'd200;
      5'd8:  ms = 10'd210;
      5'd9:  ms = 10'd220;
      5'd10: ms = 10'd230;
      5'd11: ms = 10'd240;
      5'd12: ms = 10'd250;
      5'd13: ms = 10'd260;
      5'd14: ms = 10'd270;
      5'd15: ms = 10'd280;
      5'd16: ms = 10'd290;
      5'd17: ms = 10'd300;
      5'd18: ms = 10'd320;
      5'd19: ms = 10'd340;
      5'd20: ms = 10'd360;
      5'd21: ms = 10'd380;
      5'd22: ms = 10'd400;
      5'd23: ms = 10'd420;
      5'd24: ms = 10'd440;
      5'd25: ms = 10'd460;
      5'd26: ms = 10'd480;
      5'd27: ms = 10'd500;
      5'd28: ms = 10'd525;
      5'd29: ms = 10'd550;
      5'd30: ms = 10'd600;
      5'd31: ms = 10'd650;
      default: ms = 10'd130;
    endcase
    return ms;
  endfunction

endpackage

// ----- hdl/sci_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sci_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sci_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sci_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sci_pkg::cfg_t                 cfg
);
  import sci_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_select    <= PULSE_SELECT_RST;
      cfg.catch_up_gap    <= CATCH_UP_GAP_RST;
      cfg.release_recheck <= RELEASE_RECHECK_RST;
      cfg.rearm_poll      <= REARM_POLL_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PULSE_SELECT:    cfg.pulse_select    <= cfg_data[4:0];
        REG_CATCH_UP_GAP:    cfg.catch_up_gap    <= cfg_data;
        REG_RELEASE_RECHECK: cfg.release_recheck <= cfg_data;
        REG_REARM_POLL:      cfg.rearm_poll      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/sci_minute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_minute
// Minute signal detection, true time counter, noon marker and re-arm poller.
// ----------------------------------------------------------------------------
module sci_minute #(
  parameter int MINUTES_PER_CYCLE = sci_pkg::MINUTES_PER_CYCLE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       sig,
  input  logic [7:0]                 rearm_poll,
  output sci_pkg::minute_evt_t       evt,
  output logic [sci_pkg::TIME_W-1:0] true_time,
  output logic                       noon_level
);
  import sci_pkg::*;

  localparam logic [TIME_W-1:0] Limit = TIME_W'(MINUTES_PER_CYCLE);

  logic              signal_armed, signal_armed_next;
  logic              rearm_pending, rearm_pending_next;
  logic [7:0]        rearm_wait, rearm_wait_next;
  logic [TIME_W-1:0] true_time_next;
  logic              noon_level_next;
  logic              hit;

  always_comb begin
    signal_armed_next  = signal_armed;
    rearm_pending_next = rearm_pending;
    true_time_next     = true_time;
    noon_level_next    = noon_level;
    hit                = 1'b0;

    if (signal_armed && sig) begin
      hit                = 1'b1;
      true_time_next     = next_minute(true_time, Limit);
      noon_level_next    = (true_time_next == '0);
      rearm_pending_next = 1'b1;
      signal_armed_next  = 1'b0;
    end

    // The poller may already run in the tick that disarmed the input.
    if (rearm_pending_next) begin
      if (rearm_wait == '0) begin
        if (!sig) begin
          rearm_pending_next = 1'b0;
          signal_armed_next  = 1'b1;
        end
        rearm_wait_next = (rearm_poll == '0) ? '0 : rearm_poll - 8'd1;
      end else begin
        rearm_wait_next = rearm_wait - 8'd1;
      end
    end else begin
      rearm_wait_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_armed  <= 1'b1;
      rearm_pending <= 1'b0;
      rearm_wait    <= '0;
      true_time     <= '0;
      noon_level    <= 1'b1;
    end else if (step) begin
      signal_armed  <= signal_armed_next;
      rearm_pending <= rearm_pending_next;
      rearm_wait    <= rearm_wait_next;
      true_time     <= true_time_next;
      noon_level    <= noon_level_next;
    end
  end

  assign evt.hit       = hit;
  assign evt.true_time = true_time_next;

endmodule

// ----- hdl/sci_drive.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sci_drive
// Drive sequencer: impulse on alternate coils, shown time, release recheck
// and catch-up repeats.
// ----------------------------------------------------------------------------
module sci_drive #(
  parameter int MINUTES_PER_CYCLE = sci_pkg::MINUTES_PER_CYCLE_DEF,
  parameter int WAIT_BITS         = sci_pkg::WAIT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic                       sig,
  input  logic                       pause,
  input  sci_pkg::minute_evt_t       evt,
  input  sci_pkg::cfg_t              cfg,
  output logic [1:0]                 coil_levels,
  output logic [sci_pkg::TIME_W-1:0] shown_time
);
  import sci_pkg::*;

  localparam logic [TIME_W-1:0] Limit   = TIME_W'(MINUTES_PER_CYCLE);
  localparam logic [31:0]       WaitMax = (32'd1 << WAIT_BITS) - 32'd1;

  logic                 drive_pending, drive_pending_next;
  logic                 impulse_on, impulse_on_next;
  logic [WAIT_BITS-1:0] drive_wait, drive_wait_next;
  logic [1:0]           coil_levels_next;
  logic [TIME_W-1:0]    shown_time_next;

  // A delay of D ms loads D-1; zero acts as one and long delays saturate.
  function automatic logic [WAIT_BITS-1:0] wait_load(input logic [15:0] ms);
    logic [15:0] w;
    logic [31:0] w32;
    w   = (ms == '0) ? '0 : ms - 16'd1;
    w32 = {16'd0, w};
    return (w32 > WaitMax) ? WaitMax[WAIT_BITS-1:0] : w32[WAIT_BITS-1:0];
  endfunction

  always_comb begin
    drive_pending_next = drive_pending | evt.hit;
    impulse_on_next    = impulse_on;
    drive_wait_next    = drive_wait;
    coil_levels_next   = coil_levels;
    shown_time_next    = shown_time;

    if (drive_pending_next) begin
      if (drive_wait == '0) begin
        if (!impulse_on) begin
          // While paused the on phase still lasts, but drives nothing.
          if (!pause) begin
            coil_levels_next = coil_levels | (shown_time[0] ? COIL_B : COIL_A);
            shown_time_next  = next_minute(shown_time, Limit);
          end
          impulse_on_next = 1'b1;
          drive_wait_next = wait_load({6'd0, pulse_ms(cfg.pulse_select)});
        end else begin
          coil_levels_next = COIL_NONE;
          if (sig) begin
            drive_wait_next = wait_load(cfg.release_recheck);
          end else begin
            impulse_on_next    = 1'b0;
            drive_pending_next = 1'b0;
            drive_wait_next    = '0;
            if (!pause && (shown_time != evt.true_time)) begin
              drive_pending_next = 1'b1;
              drive_wait_next    = wait_load(cfg.catch_up_gap);
            end
          end
        end
      end else begin
        drive_wait_next = drive_wait - {{(WAIT_BITS-1){1'b0}}, 1'b1};
      end
    end else begin
      drive_wait_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_pending <= 1'b0;
      impulse_on    <= 1'b0;
      drive_wait    <= '0;
      coil_levels   <= COIL_NONE;
      shown_time    <= '0;
    end else if (step) begin
      drive_pending <= drive_pending_next;
      impulse_on    <= impulse_on_next;
      drive_wait    <= drive_wait_next;
      coil_levels   <= coil_levels_next;
      shown_time    <= shown_time_next;
    end
  end

endmodule

// ----- hdl/slave_clock_impulse_driver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slave_clock_impulse_driver
// Slave clock driver: counts master minute signals and steps the dial with
// alternating coil impulses until the shown time matches true time.
// ----------------------------------------------------------------------------
// Each request is one 1 ms tick carrying the minute signal and pause switch;
// it produces exactly one result with the coil levels, noon marker and both
// times after that tick. The block takes one request every clock cycle unless
// in_stall is high; the request is held in the input register until the state
// update writes the registers that are the result. Timing figures (impulse
// length, gaps, polls) are counted in ticks, not clocks.
// The user must write configuration only while no request is in flight;
// the block itself does not enforce it.
module slave_clock_impulse_driver #(
  parameter int MINUTES_PER_CYCLE = sci_pkg::MINUTES_PER_CYCLE_DEF,
  parameter int WAIT_BITS         = sci_pkg::WAIT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            minute_signal,
  input  logic                            pause_switch,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            coil_a,
  output logic                            coil_b,
  output logic                            noon_marker,
  output logic [sci_pkg::TIME_W-1:0]      true_minutes,
  output logic [sci_pkg::TIME_W-1:0]      shown_minutes,
  input  logic                            cfg_write,
  input  logic [sci_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sci_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sci_pkg::*;

  cfg_t        cfg;
  minute_evt_t evt;
  logic        s1_valid;
  logic        s1_sig;
  logic        s1_pause;
  logic        step;
  logic [1:0]  coil_levels;

  // The state update runs when the result slot is free or being emptied.
  assign step     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sig   <= minute_signal;
      s1_pause <= pause_switch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  sci_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sci_minute #(
    .MINUTES_PER_CYCLE (MINUTES_PER_CYCLE)
  ) u_minute (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .sig        (s1_sig),
    .rearm_poll (cfg.rearm_poll),
    .evt        (evt),
    .true_time  (true_minutes),
    .noon_level (noon_marker)
  );

  sci_drive #(
    .MINUTES_PER_CYCLE (MINUTES_PER_CYCLE),
    .WAIT_BITS         (WAIT_BITS)
  ) u_drive (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .sig         (s1_sig),
    .pause       (s1_pause),
    .evt         (evt),
    .cfg         (cfg),
    .coil_levels (coil_levels),
    .shown_time  (shown_minutes)
  );

  assign coil_a = coil_levels[0];
  assign coil_b = coil_levels[1];

`ifndef NO_ASSERTIONS
  a_coils_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(coil_a && coil_b))
    else $error("both bridge halves driven at once");

  a_true_in_range: assert property (@(posedge clk) disable iff (rst)
    true_minutes < TIME_W'(MINUTES_PER_CYCLE))
    else $error("true time outside the dial cycle");

  a_shown_in_range: assert property (@(posedge clk) disable iff (rst)
    shown_minutes < TIME_W'(MINUTES_PER_CYCLE))
    else $error("shown time outside the dial cycle");

  a_time_moves_on_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (true_minutes != $past(true_minutes))) |-> $past(step))
    else $error("true time changed without a request being processed");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(out_valid && out_stall)) |->
      ($stable(shown_minutes) && $stable(coil_levels)))
    else $error("result changed while stalled");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the slave clock impulse driver. Tick requests are
// fed through a bursty driver and results are taken by a monitor behind a
// stalling receiver. A local model of the dial works out every result.
// ----------------------------------------------------------------------------
module tb;
  import sci_pkg::*;

  localparam int unsigned WAIT_MAX = (1 << WAIT_BITS_DEF) - 1;

  typedef struct packed {
    logic sig;
    logic pause;
  } tick_t;

  typedef struct packed {
    logic              coil_a;
    logic              coil_b;
    logic              noon;
    logic [TIME_W-1:0] true_m;
    logic [TIME_W-1:0] shown_m;
  } dial_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   minute_signal;
  logic                   pause_switch;
  logic                   out_valid;
  logic                   out_stall;
  logic                   coil_a;
  logic                   coil_b;
  logic                   noon_marker;
  logic [TIME_W-1:0]      true_minutes;
  logic [TIME_W-1:0]      shown_minutes;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  slave_clock_impulse_driver u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .minute_signal (minute_signal),
    .pause_switch  (pause_switch),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .coil_a        (coil_a),
    .coil_b        (coil_b),
    .noon_marker   (noon_marker),
    .true_minutes  (true_minutes),
    .shown_minutes (shown_minutes),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Dial model state and its copy of the registers.
  logic [TIME_W-1:0] true_min;
  logic [TIME_W-1:0] shown_min;
  logic              armed;
  logic              rearm_busy;
  logic [7:0]        rearm_cnt;
  logic              drive_busy;
  logic              pulse_high;
  logic [15:0]       drive_cnt;
  logic [1:0]        coils;
  logic              noon_q;
  logic [4:0]        cfg_pulse_sel;
  logic [15:0]       cfg_gap;
  logic [15:0]       cfg_recheck;
  logic [7:0]        cfg_poll;

  tick_t tick_fifo[$];
  dial_t dial_q[$];
  tick_t nxt;
  dial_t want;

  int    mismatches;
  int    reqs_accepted;
  logic  req_taken;
  int    burst_left;
  int    gap_left;
  int    hold_cnt;
  bit    hold_done;
  int    pat_mode;
  int    pat_left;
  logic  pause_lvl;
  logic  last_sig;
  int    rise_cnt;

  function automatic logic [TIME_W-1:0] step_minute(input logic [TIME_W-1:0] t);
    return (t + 1 >= MINUTES_PER_CYCLE_DEF) ? '0 : t + 1'b1;
  endfunction

  // A delay of D ms loads D-1 so the task runs again D ticks later; zero acts
  // as one tick and anything beyond the counter saturates.
  function automatic int unsigned delay_load(input int unsigned ms, input int unsigned maxv);
    int unsigned w;
    w = (ms == 0) ? 0 : ms - 1;
    return (w > maxv) ? maxv : w;
  endfunction

  // Impulse lengths rise in 10 ms steps to 300, then 20 ms steps to 500,
  // then a few coarse steps up to 650.
  function automatic int unsigned impulse_len(input logic [4:0] sel);
    if (sel <= 17) return 130 + 10 * sel;
    if (sel <= 27) return 300 + 20 * (sel - 17);
    case (sel)
      5'd28:   return 525;
      5'd29:   return 550;
      5'd30:   return 600;
      default: return 650;
    endcase
  endfunction

  function automatic dial_t predict_tick(input logic sig, input logic pause);
    dial_t r;
    if (armed && sig) begin
      true_min   = step_minute(true_min);
      noon_q     = (true_min == 0);
      drive_busy = 1'b1;
      rearm_busy = 1'b1;
      armed      = 1'b0;
    end
    if (rearm_busy) begin
      if (rearm_cnt == 0) begin
        if (!sig) begin
          rearm_busy = 1'b0;
          armed      = 1'b1;
        end
        rearm_cnt = 8'(delay_load(cfg_poll, 8'hFF));
      end else begin
        rearm_cnt--;
      end
    end else begin
      rearm_cnt = '0;
    end
    if (drive_busy) begin
      if (drive_cnt == 0) begin
        if (!pulse_high) begin
          // While paused the on phase still runs its full length, coils off.
          if (!pause) begin
            coils     = coils | (shown_min[0] ? COIL_B : COIL_A);
            shown_min = step_minute(shown_min);
          end
          pulse_high = 1'b1;
          drive_cnt  = 16'(delay_load(impulse_len(cfg_pulse_sel), WAIT_MAX));
        end else begin
          coils = COIL_NONE;
          if (sig) begin
            drive_cnt = 16'(delay_load(cfg_recheck, WAIT_MAX));
          end else begin
            pulse_high = 1'b0;
            drive_busy = 1'b0;
            drive_cnt  = '0;
            if (!pause && shown_min != true_min) begin
              drive_busy = 1'b1;
              drive_cnt  = 16'(delay_load(cfg_gap, WAIT_MAX));
            end
          end
        end
      end else begin
        drive_cnt--;
      end
    end else begin
      drive_cnt = '0;
    end
    r.coil_a  = coils[0];
    r.coil_b  = coils[1];
    r.noon    = noon_q;
    r.true_m  = true_min;
    r.shown_m = shown_min;
    return r;
  endfunction

  task automatic set_config(input logic [4:0] sel, input logic [15:0] gap,
                            input logic [15:0] recheck, input logic [7:0] poll);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_PULSE_SELECT;
    cfg_data  <= {11'd0, sel};
    @(negedge clk);
    cfg_index <= REG_CATCH_UP_GAP;
    cfg_data  <= gap;
    @(negedge clk);
    cfg_index <= REG_RELEASE_RECHECK;
    cfg_data  <= recheck;
    @(negedge clk);
    cfg_index <= REG_REARM_POLL;
    cfg_data  <= {8'd0, poll};
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_pulse_sel = sel;
    cfg_gap       = gap;
    cfg_recheck   = recheck;
    cfg_poll      = poll;
  endtask

  task automatic wait_idle();
    while (tick_fifo.size() != 0 || in_valid || dial_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_tick(input logic sig, input int noise_pct);
    tick_t t;
    if ($urandom_range(0, 59) == 0) pause_lvl = ~pause_lvl;
    if ($urandom_range(0, 99) < noise_pct) sig = 1'($urandom_range(0, 1));
    if (sig && !last_sig) rise_cnt++;
    last_sig = sig;
    t.sig    = sig;
    t.pause  = pause_lvl;
    tick_fifo.push_back(t);
  endtask

  // Minute signal pulses of random on and off lengths, with some noise.
  task automatic queue_minutes(input int n_items, input int rises_goal, input int on_max,
                               input int off_max, input int noise_pct);
    int items;
    int run;
    items    = 0;
    rise_cnt = 0;
    while (items < n_items || rise_cnt < rises_goal) begin
      run = $urandom_range(1, on_max);
      repeat (run) push_tick(1'b1, noise_pct);
      items += run;
      run = $urandom_range(1, off_max);
      repeat (run) push_tick(1'b0, noise_pct);
      items += run;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst && (!in_valid || req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_fifo.size() != 0) begin
        nxt = tick_fifo.pop_front();
        in_valid      <= 1'b1;
        minute_signal <= nxt.sig;
        pause_switch  <= nxt.pause;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 4) == 0) begin
          burst_left = $urandom_range(150, 300);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a changing stall pattern, plus one long hold-off that lets the
  // block fill up and push back on requests.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (!hold_done && reqs_accepted >= 300) begin
        hold_done = 1'b1;
        hold_cnt  = 80;
        out_stall <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 120);
        end else begin
          pat_left--;
        end
        case (pat_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ~out_stall;
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    req_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        dial_q.push_back(predict_tick(minute_signal, pause_switch));
        reqs_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (dial_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = dial_q.pop_front();
          if (coil_a !== want.coil_a) begin
            $error("coil_a: expected %0d, got %0d", want.coil_a, coil_a);
            mismatches++;
          end
          if (coil_b !== want.coil_b) begin
            $error("coil_b: expected %0d, got %0d", want.coil_b, coil_b);
            mismatches++;
          end
          if (noon_marker !== want.noon) begin
            $error("noon_marker: expected %0d, got %0d", want.noon, noon_marker);
            mismatches++;
          end
          if (true_minutes !== want.true_m) begin
            $error("true_minutes: expected %0d, got %0d", want.true_m, true_minutes);
            mismatches++;
          end
          if (shown_minutes !== want.shown_m) begin
            $error("shown_minutes: expected %0d, got %0d", want.shown_m, shown_minutes);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    logic [19:0] open_sig;
    logic [19:0] open_pause;
    tick_t       t;
    rst           = 1'b1;
    in_valid      = 1'b0;
    minute_signal = 1'b0;
    pause_switch  = 1'b0;
    out_stall     = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = REG_PULSE_SELECT;
    cfg_data      = '0;
    req_taken     = 1'b0;
    mismatches    = 0;
    reqs_accepted = 0;
    burst_left    = 0;
    gap_left      = 0;
    hold_cnt      = 0;
    hold_done     = 1'b0;
    pat_mode      = 0;
    pat_left      = 0;
    pause_lvl     = 1'b0;
    last_sig      = 1'b0;
    rise_cnt      = 0;
    true_min      = '0;
    shown_min     = '0;
    armed         = 1'b1;
    rearm_busy    = 1'b0;
    rearm_cnt     = '0;
    drive_busy    = 1'b0;
    pulse_high    = 1'b0;
    drive_cnt     = '0;
    coils         = COIL_NONE;
    noon_q        = 1'b1;
    cfg_pulse_sel = PULSE_SELECT_RST;
    cfg_gap       = CATCH_UP_GAP_RST;
    cfg_recheck   = RELEASE_RECHECK_RST;
    cfg_poll      = REARM_POLL_RST;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Opening sequence at the reset settings: a first minute clears the noon
    // marker and starts an impulse, a held signal, a minute while paused and
    // during the running impulse, and re-arming after the poll.
    open_sig   = 20'b1100_0000_1100_0000_0100;
    open_pause = 20'b0001_1000_1110_0100_0001;
    for (int i = 19; i >= 0; i--) begin
      t.sig   = open_sig[i];
      t.pause = open_pause[i];
      tick_fifo.push_back(t);
    end
    wait_idle();

    // Smallest delays, zero acting as one tick, and the longest impulse.
    set_config(5'd31, 16'd0, 16'd0, 8'd0);
    queue_minutes(150, 0, 4, 6, 10);
    wait_idle();

    // Fastest minutes the input allows; run long enough for true time to
    // wrap past noon.
    set_config(5'd0, 16'd1, 16'd1, 8'd1);
    queue_minutes(0, MINUTES_PER_CYCLE_DEF - int'(true_min) + 8, 1, 1, 4);
    wait_idle();

    set_config(5'($urandom_range(1, 30)), 16'($urandom_range(1, 40)),
               16'($urandom_range(1, 30)), 8'($urandom_range(2, 20)));
    queue_minutes(150, 0, 8, 30, 8);
    wait_idle();

    // Largest delays last, since they leave counters loaded for a long time.
    set_config(5'($urandom_range(0, 31)), 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_minutes(120, 0, 40, 40, 10);
    wait_idle();
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sci_pkg.sv
hdl/sci_cfg.sv
hdl/sci_minute.sv
hdl/sci_drive.sv
hdl/slave_clock_impulse_driver.sv
verif/tb.sv
